@@ rtl/sosc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sine oscillator package
// Shared widths, polynomial constants and control structs of the oscillator.
// ----------------------------------------------------------------------------
package sosc_pkg;

   localparam int FRAME_COUNT_BITS = 7;
   localparam int CSR_INDEX_BITS   = 2;
   localparam int CSR_DATA_BITS    = 32;
   localparam int INCREMENT_BITS   = 32;
   localparam int GAIN_BITS        = 16;
   localparam int FRACTION_BITS    = 16;
   localparam int OPERAND_BITS     = 17;
   localparam int PRODUCT_BITS     = 2 * OPERAND_BITS;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_PHASE_INCREMENT = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_AMPLITUDE_GAIN  = 2'd1;

   localparam logic [OPERAND_BITS-1:0] POLY_A = 17'd102944;
   localparam logic [OPERAND_BITS-1:0] POLY_B = 17'd42048;
   localparam logic [OPERAND_BITS-1:0] POLY_C = 17'd4640;

   typedef struct packed {
      logic start;
      logic take;
   } sine_ctrl_type;

   typedef struct packed {
      logic busy;
      logic ready;
   } sine_stat_type;

endpackage
`default_nettype wire

@@ rtl/sosc_mul.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Shared multiplier
// Unsigned 17 by 17 bit multiplier with a registered product.
// ----------------------------------------------------------------------------
module sosc_mul (
   input  wire logic                                  clock,
   input  wire logic [sosc_pkg::OPERAND_BITS-1:0]     op_a,
   input  wire logic [sosc_pkg::OPERAND_BITS-1:0]     op_b,
   output logic      [sosc_pkg::PRODUCT_BITS-1:0]     product
);

   logic [sosc_pkg::PRODUCT_BITS-1:0] product_ff;
   logic [sosc_pkg::PRODUCT_BITS-1:0] product_in;

   assign product_in = sosc_pkg::PRODUCT_BITS'(op_a) * sosc_pkg::PRODUCT_BITS'(op_b);
   assign product    = product_ff;

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

endmodule
`default_nettype wire

@@ rtl/sosc_sine.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sine sequencer
// Steps the quarter-wave polynomial, gain and rounding through the shared
// multiplier and holds the saturated sample until it is taken.
// ----------------------------------------------------------------------------
module sosc_sine #(
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire sosc_pkg::sine_ctrl_type               ctrl,
   output sosc_pkg::sine_stat_type                    stat,
   input  wire logic [1:0]                            quadrant,
   input  wire logic [sosc_pkg::FRACTION_BITS-1:0]    fraction,
   input  wire logic [sosc_pkg::GAIN_BITS-1:0]        gain,
   output logic      [SAMPLE_BITS-1:0]                sample
);

   localparam int OB       = sosc_pkg::OPERAND_BITS;
   localparam int PB       = sosc_pkg::PRODUCT_BITS;
   localparam int MAG_BITS = SAMPLE_BITS + 3;
   localparam logic [PB:0]         ROUND_HALF = (PB + 1)'(1) << (31 - SAMPLE_BITS);
   localparam logic [MAG_BITS-1:0] POS_LIMIT  = MAG_BITS'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
   localparam logic [MAG_BITS-1:0] NEG_LIMIT  = MAG_BITS'(64'd1 << (SAMPLE_BITS - 1));

   typedef enum logic [3:0] {
      S_IDLE, S_SQUARE, S_POLY_C, S_POLY_B, S_POLY_T, S_POLY_A, S_PROD_S,
      S_GAIN, S_ROUND, S_CLAMP, S_DONE
   } state_type;

   state_type                state_ff, state_in;
   logic [OB-1:0]            x_ff, x_in;
   logic [OB-1:0]            x2_ff, x2_in;
   logic [OB-1:0]            t_ff, t_in;
   logic                     neg_ff, neg_in;
   logic [MAG_BITS-1:0]      mag_ff, mag_in;
   logic [SAMPLE_BITS-1:0]   sample_ff, sample_in;

   logic [OB-1:0]            op_a;
   logic [OB-1:0]            op_b;
   logic [PB-1:0]            product;
   logic [OB-1:0]            prod_hi;
   logic [PB:0]              rounded;
   logic [MAG_BITS-1:0]      clamped;
   logic [MAG_BITS-1:0]      negated;

   sosc_mul u_mul (
      .clock   (clock),
      .op_a    (op_a),
      .op_b    (op_b),
      .product (product)
   );

   assign prod_hi = product[PB-2:16];
   assign rounded = (PB + 1)'(product) + ROUND_HALF;

   always_comb begin
      if (neg_ff) begin
         clamped = (mag_ff > NEG_LIMIT) ? NEG_LIMIT : mag_ff;
      end else begin
         clamped = (mag_ff > POS_LIMIT) ? POS_LIMIT : mag_ff;
      end
      negated = MAG_BITS'(0) - clamped;
   end

   always_comb begin
      op_a = x_ff;
      op_b = x_ff;
      case (state_ff)
         S_POLY_C: begin
            op_a = sosc_pkg::POLY_C;
            op_b = prod_hi;
         end
         S_POLY_T: begin
            op_a = t_ff;
            op_b = x2_ff;
         end
         S_PROD_S: begin
            op_a = x_ff;
            op_b = t_ff;
         end
         S_GAIN: begin
            op_a = OB'(gain);
            op_b = prod_hi;
         end
         default: begin
            op_a = x_ff;
            op_b = x_ff;
         end
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      x_in      = x_ff;
      x2_in     = x2_ff;
      t_in      = t_ff;
      neg_in    = neg_ff;
      mag_in    = mag_ff;
      sample_in = sample_ff;
      case (state_ff)
         S_IDLE: begin
            if (ctrl.start) begin
               x_in     = quadrant[0] ? (OB'(1) << sosc_pkg::FRACTION_BITS) - OB'(fraction)
                                      : OB'(fraction);
               neg_in   = quadrant[1];
               state_in = S_SQUARE;
            end
         end
         S_SQUARE: begin
            state_in = S_POLY_C;
         end
         S_POLY_C: begin
            x2_in    = prod_hi;
            state_in = S_POLY_B;
         end
         S_POLY_B: begin
            t_in     = sosc_pkg::POLY_B - prod_hi;
            state_in = S_POLY_T;
         end
         S_POLY_T: begin
            state_in = S_POLY_A;
         end
         S_POLY_A: begin
            t_in     = sosc_pkg::POLY_A - prod_hi;
            state_in = S_PROD_S;
         end
         S_PROD_S: begin
            state_in = S_GAIN;
         end
         S_GAIN: begin
            state_in = S_ROUND;
         end
         S_ROUND: begin
            mag_in   = rounded[PB:32-SAMPLE_BITS];
            state_in = S_CLAMP;
         end
         S_CLAMP: begin
            sample_in = neg_ff ? negated[SAMPLE_BITS-1:0] : clamped[SAMPLE_BITS-1:0];
            state_in  = S_DONE;
         end
         S_DONE: begin
            if (ctrl.take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      x_ff      <= x_in;
      x2_ff     <= x2_in;
      t_ff      <= t_in;
      neg_ff    <= neg_in;
      mag_ff    <= mag_in;
      sample_ff <= sample_in;
   end

   assign stat.busy  = (state_ff != S_IDLE);
   assign stat.ready = (state_ff == S_DONE);
   assign sample     = sample_ff;

endmodule
`default_nettype wire

@@ rtl/sine_oscillator_block.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sine oscillator block
// Numerically controlled oscillator that produces blocks of sine samples.
// ----------------------------------------------------------------------------
// Each request item asks for a block of frames; the block returns one sample
// item per frame and marks the final one with last_frame, advancing a phase
// accumulator by phase_increment after every frame. The five products of a
// frame are computed in turn by one shared 17 by 17 bit multiplier, and a
// stall on the result side holds the next frame back. A new request item
// is taken once the previous block has been fully computed.
module sine_oscillator_block #(
   parameter int MAX_FRAMES  = 64,
   parameter int PHASE_BITS  = 32,
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic                                       clock,
   input  wire logic                                       reset,
   input  wire logic                                       req_valid,
   output logic                                            req_ready,
   input  wire logic [sosc_pkg::FRAME_COUNT_BITS-1:0]      req_frame_count,
   output logic                                            rsp_valid,
   input  wire logic                                       rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]                   rsp_sample,
   output logic                                            rsp_last_frame,
   input  wire logic                                       csr_valid,
   output logic                                            csr_ready,
   input  wire logic [sosc_pkg::CSR_INDEX_BITS-1:0]        csr_index,
   input  wire logic [sosc_pkg::CSR_DATA_BITS-1:0]         csr_data
);

   localparam int FCB = sosc_pkg::FRAME_COUNT_BITS;
   localparam logic [FCB-1:0] FRAMES_CAP =
      (MAX_FRAMES > (1 << FCB) - 1) ? {FCB{1'b1}} : FCB'(MAX_FRAMES);
   localparam logic [sosc_pkg::GAIN_BITS-1:0]      GAIN_RESET          = 16'd32768;

   typedef enum logic [1:0] {
      F_IDLE, F_START, F_WAIT
   } state_type;

   state_type                                state_ff, state_in;
   logic [FCB-1:0]                           remaining_ff, remaining_in;
   logic [PHASE_BITS-1:0]                    phase_ff, phase_in;
   logic [sosc_pkg::INCREMENT_BITS-1:0]      increment_ff, increment_in;
   logic [sosc_pkg::GAIN_BITS-1:0]           gain_ff, gain_in;
   logic                                     rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_BITS-1:0]                   rsp_sample_ff, rsp_sample_in;
   logic                                     rsp_last_ff, rsp_last_in;

   sosc_pkg::sine_ctrl_type                  ctrl;
   sosc_pkg::sine_stat_type                  stat;
   logic [SAMPLE_BITS-1:0]                   sine_sample;
   logic [31:0]                              aligned;
   logic [PHASE_BITS-1:0]                    phase_next;
   logic [FCB-1:0]                           frames;
   logic                                     out_free;

   if (PHASE_BITS >= 32) begin : g_phase_wide
      assign aligned    = phase_ff[PHASE_BITS-1 -: 32];
      assign phase_next = phase_ff + PHASE_BITS'(increment_ff);
   end else begin : g_phase_narrow
      assign aligned    = {phase_ff, {(32 - PHASE_BITS){1'b0}}};
      assign phase_next = phase_ff + increment_ff[PHASE_BITS-1:0];
   end

   sosc_sine #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_sine (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl),
      .stat     (stat),
      .quadrant (aligned[31:30]),
      .fraction (aligned[29:14]),
      .gain     (gain_ff),
      .sample   (sine_sample)
   );

   assign frames     = (req_frame_count > FRAMES_CAP) ? FRAMES_CAP : req_frame_count;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign ctrl.start = (state_ff == F_START) && !stat.busy;
   assign ctrl.take  = (state_ff == F_WAIT) && stat.ready && out_free;

   always_comb begin
      state_in      = state_ff;
      remaining_in  = remaining_ff;
      phase_in      = phase_ff;
      increment_in  = increment_ff;
      gain_in       = gain_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_sample_in = rsp_sample_ff;
      rsp_last_in   = rsp_last_ff;
      if (csr_valid) begin
         case (csr_index)
            sosc_pkg::CSR_PHASE_INCREMENT: begin
               increment_in = csr_data[sosc_pkg::INCREMENT_BITS-1:0];
            end
            sosc_pkg::CSR_AMPLITUDE_GAIN: begin
               gain_in = csr_data[sosc_pkg::GAIN_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
      case (state_ff)
         F_IDLE: begin
            if (req_valid && frames != '0) begin
               remaining_in = frames;
               state_in     = F_START;
            end
         end
         F_START: begin
            if (!stat.busy) begin
               state_in = F_WAIT;
            end
         end
         F_WAIT: begin
            if (ctrl.take) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = sine_sample;
               rsp_last_in   = (remaining_ff == FCB'(1));
               phase_in      = phase_next;
               remaining_in  = remaining_ff - FCB'(1);
               state_in      = (remaining_ff == FCB'(1)) ? F_IDLE : F_START;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= F_IDLE;
         phase_ff     <= '0;
         increment_ff <= '0;
         gain_ff      <= GAIN_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         increment_ff <= increment_in;
         gain_ff      <= gain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      remaining_ff  <= remaining_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign req_ready      = (state_ff == F_IDLE);
   assign csr_ready      = 1'b1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample     = rsp_sample_ff;
   assign rsp_last_frame = rsp_last_ff;

endmodule
`default_nettype wire

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sine oscillator block testbench
// Sends frame-count requests to the oscillator and checks every returned
// sample and end-of-block flag against a bit-exact model of the phase
// accumulator, the quarter-wave polynomial and the gain stage. A directed
// part covers the field and register extremes. Random parts then follow
// under three pacing modes for the request and result handshakes.
// ----------------------------------------------------------------------------
module testbench;

   localparam int SAMPLE_BITS   = 16;
   localparam int MAX_FRAMES    = 64;
   localparam int CYCLE_LIMIT   = 3_000_000;
   localparam int SETTLE_CYCLES = 100;
   localparam int FCB           = sosc_pkg::FRAME_COUNT_BITS;
   localparam int CIB           = sosc_pkg::CSR_INDEX_BITS;
   localparam int CDB           = sosc_pkg::CSR_DATA_BITS;
   localparam int GB            = sosc_pkg::GAIN_BITS;
   localparam int IB            = sosc_pkg::INCREMENT_BITS;

   localparam logic [CIB-1:0] CSR_UNMAPPED_LOW    = 2'd2;
   localparam logic [CIB-1:0] CSR_UNMAPPED_HIGH   = 2'd3;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          is_last;
   } sine_frame_type;

   typedef struct {
      logic [FCB-1:0]              frame_count;
      bit                          hold_for_drain;
   } block_request_type;

   logic                              clock           = 1'b0;
   logic                              reset           = 1'b1;
   logic                              req_valid       = 1'b0;
   wire                               req_ready;
   logic [FCB-1:0]                    req_frame_count = '0;
   wire                               rsp_valid;
   logic                              rsp_ready       = 1'b0;
   wire signed [SAMPLE_BITS-1:0]      rsp_sample;
   wire                               rsp_last_frame;
   logic                              csr_valid       = 1'b0;
   wire                               csr_ready;
   logic [CIB-1:0]                    csr_index       = '0;
   logic [CDB-1:0]                    csr_data        = '0;

   block_request_type                 block_requests[$];
   sine_frame_type                    frames_due[$];

   logic [IB-1:0]                     phase_step         = '0;
   logic [GB-1:0]                     amplitude_gain_q15 = 16'd32768;
   logic [31:0]                       phase_acc          = '0;

   int                                sender_idle_pct    = 0;
   int                                receiver_stall_pct = 0;
   bit                                request_taken      = 1'b0;
   int                                mismatches         = 0;
   int                                frames_checked     = 0;
   int                                blocks_sent        = 0;
   int                                empty_blocks       = 0;
   int                                clamped_blocks     = 0;
   int                                register_writes    = 0;
   int                                cycle_count        = 0;

   sine_oscillator_block #(
      .MAX_FRAMES (MAX_FRAMES),
      .PHASE_BITS (32),
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_frame_count(req_frame_count),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sample     (rsp_sample),
      .rsp_last_frame (rsp_last_frame),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic signed [SAMPLE_BITS-1:0] sine_of_phase(
      input logic [31:0]          phase,
      input logic [GB-1:0]        gain_q15
   );
      logic [1:0]  quadrant;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] poly;
      logic [63:0] magnitude_q16;
      logic [63:0] product;
      logic [63:0] rounded;
      longint      signed_value;
      quadrant      = phase[31:30];
      x             = quadrant[0] ? 64'd65536 - 64'(phase[29:14]) : 64'(phase[29:14]);
      x2            = (x * x) >> 16;
      poly          = 64'(sosc_pkg::POLY_B) - ((64'(sosc_pkg::POLY_C) * x2) >> 16);
      poly          = 64'(sosc_pkg::POLY_A) - ((poly * x2) >> 16);
      magnitude_q16 = (x * poly) >> 16;
      product       = 64'(gain_q15) * magnitude_q16;
      rounded       = (product + 64'd32768) >> 16;
      if (rounded > 64'd32768) begin
         rounded = 64'd32768;
      end
      signed_value = quadrant[1] ? -longint'(rounded) : longint'(rounded);
      if (signed_value > 32767) begin
         signed_value = 32767;
      end
      if (signed_value < -32768) begin
         signed_value = -32768;
      end
      return SAMPLE_BITS'(signed_value);
   endfunction

   task automatic predict_block(input logic [FCB-1:0] count);
      int             frames;
      sine_frame_type frame;
      frames = (count > MAX_FRAMES) ? MAX_FRAMES : int'(count);
      blocks_sent++;
      if (frames == 0) begin
         empty_blocks++;
      end
      if (count > MAX_FRAMES) begin
         clamped_blocks++;
      end
      for (int k = 0; k < frames; k++) begin
         frame.sample  = sine_of_phase(phase_acc, amplitude_gain_q15);
         frame.is_last = (k == frames - 1);
         frames_due.push_back(frame);
         phase_acc = phase_acc + phase_step;
      end
   endtask

   always @(posedge clock) begin
      sine_frame_type due;
      if (!reset && req_valid && req_ready) begin
         predict_block(req_frame_count);
         void'(block_requests.pop_front());
         request_taken = 1'b1;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (frames_due.size() == 0) begin
            $display("%0t: unexpected sample %0d last_frame %0b", $time, rsp_sample,
                     rsp_last_frame);
            mismatches++;
         end else begin
            due = frames_due.pop_front();
            frames_checked++;
            if (rsp_sample !== due.sample) begin
               $display("%0t: sample expected %0d actual %0d", $time, due.sample, rsp_sample);
               mismatches++;
            end
            if (rsp_last_frame !== due.is_last) begin
               $display("%0t: last_frame expected %0b actual %0b", $time, due.is_last,
                        rsp_last_frame);
               mismatches++;
            end
         end
      end
   end

   always @(negedge clock) begin
      if (!req_valid || request_taken) begin
         if (block_requests.size() != 0 &&
             !(block_requests[0].hold_for_drain && frames_due.size() != 0) &&
             $urandom_range(0, 99) >= sender_idle_pct) begin
            req_valid       <= 1'b1;
            req_frame_count <= block_requests[0].frame_count;
         end else begin
            req_valid       <= 1'b0;
            req_frame_count <= FCB'($urandom);
         end
      end
      request_taken = 1'b0;
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d samples outstanding.", cycle_count,
                  frames_due.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic write_register(input logic [CIB-1:0] index,
                                 input logic [CDB-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      case (index)
         sosc_pkg::CSR_PHASE_INCREMENT: begin
            phase_step = data[IB-1:0];
         end
         sosc_pkg::CSR_AMPLITUDE_GAIN: begin
            amplitude_gain_q15 = data[GB-1:0];
         end
         default: begin
         end
      endcase
      register_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic queue_block(input int count, input bit hold_for_drain);
      block_request_type request;
      request.frame_count    = FCB'(count);
      request.hold_for_drain = hold_for_drain;
      block_requests.push_back(request);
   endtask

   task automatic wait_until_idle();
      while (block_requests.size() != 0 || frames_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic int random_frame_count();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
         return $urandom_range(1, 16);
      end else if (roll < 88) begin
         return $urandom_range(17, MAX_FRAMES);
      end else if (roll < 93) begin
         return 0;
      end
      return $urandom_range(MAX_FRAMES + 1, 127);
   endfunction

   function automatic logic [IB-1:0] random_increment();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return $urandom_range(1, 1 << 20);
         2: return 32'h8000_0000 ^ 32'($urandom_range(0, 255));
         default: return ~32'($urandom_range(0, 4095));
      endcase
   endfunction

   function automatic logic [GB-1:0] random_gain();
      case ($urandom_range(0, 3))
         0: return 16'($urandom_range(0, 65535));
         1: return 16'd32768;
         2: return 16'($urandom_range(0, 32768));
         default: return 16'($urandom_range(40000, 65535));
      endcase
   endfunction

   initial begin
      sender_idle_pct    = 23;
      receiver_stall_pct = 48;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      queue_block(1, 1'b0);
      queue_block(0, 1'b0);
      queue_block(2, 1'b0);
      wait_until_idle();

      write_register(sosc_pkg::CSR_PHASE_INCREMENT, 32'h4000_0000);
      queue_block(4, 1'b0);
      queue_block(64, 1'b0);
      queue_block(0, 1'b0);
      queue_block(127, 1'b0);
      queue_block(65, 1'b0);
      wait_until_idle();

      write_register(sosc_pkg::CSR_AMPLITUDE_GAIN, 32'h0000_FFFF);
      write_register(sosc_pkg::CSR_PHASE_INCREMENT, 32'h0123_4567);
      queue_block(64, 1'b0);
      queue_block(33, 1'b0);
      wait_until_idle();

      write_register(sosc_pkg::CSR_AMPLITUDE_GAIN, 32'hFFFF_0000);
      queue_block(8, 1'b0);
      wait_until_idle();

      write_register(CSR_UNMAPPED_LOW, 32'hFFFF_FFFF);
      write_register(CSR_UNMAPPED_HIGH, 32'h1234_5678);
      write_register(sosc_pkg::CSR_PHASE_INCREMENT, 32'hFFFF_FFFF);
      write_register(sosc_pkg::CSR_AMPLITUDE_GAIN, 32'hABCD_8000);
      queue_block(16, 1'b0);
      queue_block(1, 1'b0);
      queue_block(3, 1'b0);
      wait_until_idle();

      write_register(sosc_pkg::CSR_PHASE_INCREMENT, 32'h8000_0000);
      write_register(sosc_pkg::CSR_AMPLITUDE_GAIN, 32'h0000_7FFF);
      queue_block(5, 1'b0);
      wait_until_idle();

      for (int pace = 0; pace < 3; pace++) begin
         case (pace)
            0: begin
               sender_idle_pct    = 23;
               receiver_stall_pct = 48;
            end
            1: begin
               sender_idle_pct    = 48;
               receiver_stall_pct = 23;
            end
            default: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 0;
            end
         endcase
         for (int setting = 0; setting < 4; setting++) begin
            if ($urandom_range(0, 3) == 0) begin
               write_register($urandom_range(0, 1) ? CSR_UNMAPPED_LOW : CSR_UNMAPPED_HIGH,
                              $urandom);
            end
            write_register(sosc_pkg::CSR_PHASE_INCREMENT, random_increment());
            write_register(sosc_pkg::CSR_AMPLITUDE_GAIN, {16'($urandom), random_gain()});
            for (int i = 0; i < 35; i++) begin
               queue_block(random_frame_count(),
                           (i == 10 && setting == 0) || $urandom_range(0, 29) == 0);
            end
            wait_until_idle();
         end
      end

      $display("Checked %0d samples from %0d request items, %0d of them empty and %0d clamped.",
               frames_checked, blocks_sent, empty_blocks, clamped_blocks);
      $display("Applied %0d register writes under three handshake pacing modes.",
               register_writes);
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
